// File: rtl/lpw_pkg.sv
// ----------------------------------------------------------------------------
// lpw_pkg: shared types and constants for the panel window write controller
// Command codes, register offsets, panel ID bytes and window/pointer structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpw_pkg;

	// default panel geometry
	localparam int unsigned DEF_PANEL_WIDTH  = 320;
	localparam int unsigned DEF_PANEL_HEIGHT = 240;

	// register map (byte offsets)
	localparam logic [11:0] OFF_CTRL     = 12'h000;
	localparam logic [11:0] OFF_CMD      = 12'h004;
	localparam logic [11:0] OFF_RD_CMD   = 12'h00c;
	localparam logic [11:0] OFF_RD_TRIG  = 12'h010;
	localparam logic [11:0] OFF_RD_BUF   = 12'h014;
	localparam logic [11:0] OFF_INT_CTRL = 12'h018;
	localparam logic [11:0] OFF_STATUS   = 12'h01c;
	localparam logic [11:0] OFF_PHASE    = 12'h020;

	// data port spans 0x40..0x5f
	localparam logic [6:0] DATA_PORT_HI = 7'h02;

	// bus access kinds
	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// panel command words
	localparam logic [31:0] CMD_HADDR  = 32'h0000_0200;
	localparam logic [31:0] CMD_VADDR  = 32'h0000_0201;
	localparam logic [31:0] CMD_WGRAM  = 32'h0000_0202;
	localparam logic [31:0] CMD_HSTART = 32'h0000_0210;
	localparam logic [31:0] CMD_HEND   = 32'h0000_0211;
	localparam logic [31:0] CMD_VSTART = 32'h0000_0212;
	localparam logic [31:0] CMD_VEND   = 32'h0000_0213;
	localparam logic [31:0] CMD_CASET  = 32'h0000_002a;
	localparam logic [31:0] CMD_RASET  = 32'h0000_002b;
	localparam logic [31:0] CMD_RAMWR  = 32'h0000_002c;

	// status word: base value and ready flag
	localparam logic [31:0] STATUS_BASE  = 32'h0000_0002;
	localparam logic [31:0] STATUS_READY = 32'h0000_0001;

	// panel ID bytes returned after a read-command write
	localparam logic [7:0] PANEL_ID [4] = '{8'h38, 8'hb3, 8'h71, 8'h00};

	// number of address-set parameter bytes
	localparam logic [2:0] PARAM_FULL = 3'd4;

	typedef enum logic [3:0] {
		K_NONE   = 4'd0,
		K_HADDR  = 4'd1,
		K_VADDR  = 4'd2,
		K_WGRAM  = 4'd3,
		K_HSTART = 4'd4,
		K_HEND   = 4'd5,
		K_VSTART = 4'd6,
		K_VEND   = 4'd7,
		K_CASET  = 4'd8,
		K_RASET  = 4'd9,
		K_RAMWR  = 4'd10
	} cmd_kind_t;

	typedef struct packed {
		logic [15:0] x_start;
		logic [15:0] x_end;
		logic [15:0] y_start;
		logic [15:0] y_end;
	} win_t;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
	} ptr_t;

	function automatic cmd_kind_t decode_cmd(input logic [31:0] c);
		cmd_kind_t k;
		unique case (c)
			CMD_HADDR:  k = K_HADDR;
			CMD_VADDR:  k = K_VADDR;
			CMD_WGRAM:  k = K_WGRAM;
			CMD_HSTART: k = K_HSTART;
			CMD_HEND:   k = K_HEND;
			CMD_VSTART: k = K_VSTART;
			CMD_VEND:   k = K_VEND;
			CMD_CASET:  k = K_CASET;
			CMD_RASET:  k = K_RASET;
			CMD_RAMWR:  k = K_RAMWR;
			default:    k = K_NONE;
		endcase
		return k;
	endfunction

endpackage

// File: rtl/lpw_ptr_step.sv
// ----------------------------------------------------------------------------
// lpw_ptr_step: GRAM pointer advance inside the active window
// Steps the pointer along a row, wrapping to the window start column and
// moving to the next row, or back to the window start row at the bottom.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpw_ptr_step
	import lpw_pkg::*;
(
	input  ptr_t cur,
	input  win_t win,
	output ptr_t nxt
);

	// row end wraps x; bottom of window wraps y
	always_comb begin
		nxt = cur;
		if (cur.x >= win.x_end) begin
			nxt.x = win.x_start;
			if (cur.y >= win.y_end) begin
				nxt.y = win.y_start;
			end else begin
				nxt.y = cur.y + 16'd1;
			end
		end else begin
			nxt.x = cur.x + 16'd1;
		end
	end

endmodule

// File: rtl/lcd_panel_window_write_controller.sv
// ----------------------------------------------------------------------------
// lcd_panel_window_write_controller: panel command/data port with GRAM window
// Decodes bus accesses to the panel registers and emits addressed pixels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Each bus request (read or write) produces exactly one response carrying
// read data and, for pixel data writes, the pixel's column, row and RGB565
// color. A request is accepted every clock while in_stall is low, and its
// response is registered in the output register. The only back-pressure is
// that output register: in_stall is high while a response is held by
// out_stall, so the sustained rate is one request per cycle whenever the
// consumer keeps up. All register decode, command decode, parameter
// collection and pointer stepping finish within the accept cycle.

module lcd_panel_window_write_controller
	import lpw_pkg::*;
#(
	parameter int unsigned PANEL_WIDTH  = DEF_PANEL_WIDTH,
	parameter int unsigned PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [11:0] reg_offset,
	input  logic [31:0] write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic        pixel_write,
	output logic [8:0]  pixel_col,
	output logic [7:0]  pixel_row,
	output logic [15:0] pixel_color
);

	localparam logic [15:0] WIN_X_RST = 16'(PANEL_WIDTH - 1);
	localparam logic [15:0] WIN_Y_RST = 16'(PANEL_HEIGHT - 1);
	localparam logic [15:0] PANEL_W   = 16'(PANEL_WIDTH);
	localparam logic [15:0] PANEL_H   = 16'(PANEL_HEIGHT);

	// architectural state
	logic [31:0] ctrl_q, int_ctrl_q, phase_q;
	cmd_kind_t   kind_q;
	logic [2:0]  param_cnt_q;
	logic [7:0]  param_q [4];
	logic        stream_q;
	win_t        win_q;
	ptr_t        ptr_q;
	logic        id_loaded_q;
	logic [1:0]  rd_idx_q;
	logic        rd_ready_q;

	// response register
	logic        out_valid_q;
	logic [31:0] rdata_q;
	logic        pix_wr_q;
	logic [8:0]  pix_col_q;
	logic [7:0]  pix_row_q;
	logic [15:0] pix_color_q;

	// next-state values
	logic [31:0] ctrl_d, int_ctrl_d, phase_d;
	cmd_kind_t   kind_d;
	logic [2:0]  param_cnt_d;
	logic [7:0]  param_d [4];
	logic        stream_d;
	win_t        win_d;
	ptr_t        ptr_d;
	logic        id_loaded_d;
	logic [1:0]  rd_idx_d;
	logic        rd_ready_d;
	logic [31:0] rdata_d;
	logic        pix_wr_d;
	logic [8:0]  pix_col_d;
	logic [7:0]  pix_row_d;
	logic [15:0] pix_color_d;

	logic        in_acc;
	logic        data_port;
	logic [15:0] lo9;
	ptr_t        ptr_step;
	cmd_kind_t   new_kind;

	assign in_stall  = out_valid_q & out_stall;
	assign in_acc    = in_valid & ~in_stall;
	assign data_port = (reg_offset[11:5] == DATA_PORT_HI);
	assign lo9       = {7'd0, write_data[8:0]};
	assign new_kind  = decode_cmd(write_data);

	lpw_ptr_step u_ptr_step (
		.cur (ptr_q),
		.win (win_q),
		.nxt (ptr_step)
	);

	// request decode and state update
	always_comb begin
		ctrl_d      = ctrl_q;
		int_ctrl_d  = int_ctrl_q;
		phase_d     = phase_q;
		kind_d      = kind_q;
		param_cnt_d = param_cnt_q;
		param_d     = param_q;
		stream_d    = stream_q;
		win_d       = win_q;
		ptr_d       = ptr_q;
		id_loaded_d = id_loaded_q;
		rd_idx_d    = rd_idx_q;
		rd_ready_d  = rd_ready_q;
		rdata_d     = '0;
		pix_wr_d    = 1'b0;
		pix_col_d   = '0;
		pix_row_d   = '0;
		pix_color_d = '0;

		if (req_type == REQ_READ) begin
			unique case (reg_offset)
				OFF_CTRL:     rdata_d = ctrl_q;
				OFF_STATUS:   rdata_d = STATUS_BASE | (rd_ready_q ? STATUS_READY : '0);
				OFF_RD_BUF: begin
					rd_ready_d = 1'b0;
					rdata_d    = id_loaded_q ? {23'd0, PANEL_ID[rd_idx_q], 1'b0} : '0;
					rd_idx_d   = rd_idx_q + 2'd1;
				end
				OFF_INT_CTRL: rdata_d = int_ctrl_q;
				OFF_PHASE:    rdata_d = phase_q;
				default:      rdata_d = '0;
			endcase
		end else if (data_port) begin
			if (stream_q) begin
				// pixel stream: emit if inside the panel, always step
				if (ptr_q.x < PANEL_W && ptr_q.y < PANEL_H) begin
					pix_wr_d    = 1'b1;
					pix_col_d   = ptr_q.x[8:0];
					pix_row_d   = ptr_q.y[7:0];
					pix_color_d = write_data[15:0];
				end
				ptr_d = ptr_step;
			end else begin
				unique case (kind_q)
					K_HADDR:  ptr_d.x       = lo9;
					K_VADDR:  ptr_d.y       = lo9;
					K_HSTART: win_d.x_start = lo9;
					K_HEND:   win_d.x_end   = lo9;
					K_VSTART: win_d.y_start = lo9;
					K_VEND:   win_d.y_end   = lo9;
					K_CASET, K_RASET: begin
						// collect four bytes, then load start/end each word
						if (param_cnt_q < PARAM_FULL) begin
							param_d[param_cnt_q[1:0]] = write_data[7:0];
							param_cnt_d = param_cnt_q + 3'd1;
						end
						if (param_cnt_d == PARAM_FULL) begin
							if (kind_q == K_CASET) begin
								win_d.x_start = {param_d[0], param_d[1]};
								win_d.x_end   = {param_d[2], param_d[3]};
							end else begin
								win_d.y_start = {param_d[0], param_d[1]};
								win_d.y_end   = {param_d[2], param_d[3]};
							end
						end
					end
					default: ;
				endcase
			end
		end else begin
			unique case (reg_offset)
				OFF_CTRL: ctrl_d = write_data;
				OFF_CMD: begin
					kind_d      = new_kind;
					param_cnt_d = '0;
					stream_d    = 1'b0;
					if (new_kind == K_WGRAM || new_kind == K_RAMWR) begin
						ptr_d.x  = win_q.x_start;
						ptr_d.y  = win_q.y_start;
						stream_d = 1'b1;
					end
				end
				OFF_RD_CMD: begin
					rd_idx_d    = '0;
					id_loaded_d = 1'b1;
					rd_ready_d  = 1'b0;
				end
				OFF_RD_TRIG:  rd_ready_d = 1'b1;
				OFF_INT_CTRL: int_ctrl_d = write_data;
				OFF_PHASE:    phase_d    = write_data;
				default: ;
			endcase
		end
	end

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q      <= '0;
			int_ctrl_q  <= '0;
			phase_q     <= '0;
			kind_q      <= K_NONE;
			param_cnt_q <= '0;
			stream_q    <= 1'b0;
			win_q       <= '{x_start: 16'd0, x_end: WIN_X_RST,
			                 y_start: 16'd0, y_end: WIN_Y_RST};
			ptr_q       <= '0;
			id_loaded_q <= 1'b0;
			rd_idx_q    <= '0;
			rd_ready_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				ctrl_q      <= ctrl_d;
				int_ctrl_q  <= int_ctrl_d;
				phase_q     <= phase_d;
				kind_q      <= kind_d;
				param_cnt_q <= param_cnt_d;
				stream_q    <= stream_d;
				win_q       <= win_d;
				ptr_q       <= ptr_d;
				id_loaded_q <= id_loaded_d;
				rd_idx_q    <= rd_idx_d;
				rd_ready_q  <= rd_ready_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// parameter bytes and response payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			param_q     <= param_d;
			rdata_q     <= rdata_d;
			pix_wr_q    <= pix_wr_d;
			pix_col_q   <= pix_col_d;
			pix_row_q   <= pix_row_d;
			pix_color_q <= pix_color_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = rdata_q;
	assign pixel_write = pix_wr_q;
	assign pixel_col   = pix_col_q;
	assign pixel_row   = pix_row_q;
	assign pixel_color = pix_color_q;

`ifndef ASSERT_OFF
	// pixel responses come only from writes, which return zero read data
	a_pix_no_rdata: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_write |-> read_data == 32'd0)
		else $error("pixel response carries read data");

	// streaming only after a memory-write command, with no parameters pending
	a_stream_state: assert property (@(posedge clk) disable iff (!arst_n)
		stream_q |-> param_cnt_q == 3'd0 && (kind_q == K_WGRAM || kind_q == K_RAMWR))
		else $error("pixel stream with inconsistent command state");

	// a response appears only after an accepted request
	a_resp_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall))
		else $error("response without accepted request");

	// parameter count never passes four
	a_param_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		param_cnt_q <= PARAM_FULL)
		else $error("parameter count overflow");
`endif

endmodule
